/* rtl/lal_pkg.sv */
// shared types and constants of the lease allocator
package lal_pkg;

  // item field widths
  localparam int MacW     = 48;
  localparam int IpW      = 32;
  localparam int SfxW     = 8;
  localparam int PrefixW  = 24;
  localparam int BaseW    = 8;
  localparam int CountW   = 7;
  localparam int EntryW   = MacW + SfxW;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // register reset values
  localparam logic [PrefixW-1:0] PrefixRst = 24'hC0A804;
  localparam logic [BaseW-1:0]   BaseRst   = 8'd100;
  localparam logic [CountW-1:0]  CountRst  = 7'd51;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SERVER_PREFIX = 2'd0,
    REG_POOL_BASE     = 2'd1,
    REG_POOL_COUNT    = 2'd2
  } lal_reg_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word, clear scan state
    logic mark;      // honoured request: set suffix, mark its slot if in the pool
    logic tbl_rd;    // read client entry at table counter
    logic tbl_inc;   // step table counter
    logic tbl_wr;    // record client at table counter
    logic tbl_hit;   // take suffix from the entry just read
    logic slot_inc;  // step slot counter
    logic slot_take; // take slot at slot counter
    logic finish;    // move result into output register
  } lal_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic honour;    // acknowledge for a leasable address in our subnet
    logic tbl_end;   // table counter past last entry
    logic tbl_empty; // entry at table counter never written
    logic tbl_match; // entry read holds this client
    logic slot_end;  // slot counter past last active slot
    logic slot_ok;   // slot at slot counter is free and leasable
    logic out_busy;  // output register holds a word not yet taken
  } lal_sts_t;

endpackage

/* rtl/lal_ram.sv */
// generic single-port-write ram with registered read
module lal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lal_dp.sv */
// datapath: config registers, slot bitmap, client table, scan counters, output register
module lal_dp #(
  parameter int POOL_SLOTS     = 64,
  parameter int CLIENT_ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [lal_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lal_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [79:0]                    in_data_i,
  input  logic                           in_user_i,
  input  logic                           out_ready_i,
  input  lal_pkg::lal_cmd_t              cmd_i,
  output lal_pkg::lal_sts_t              sts_o,
  output logic                           out_valid_o,
  output logic                           out_user_o,
  output logic [39:0]                    out_data_o
);
  import lal_pkg::*;

  localparam int TIW = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam int TCW = $clog2(CLIENT_ENTRIES + 1);
  localparam int SIW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int SCW = $clog2(POOL_SLOTS + 1);

  logic [PrefixW-1:0] prefix_q;
  logic [BaseW-1:0]   base_q;
  logic [CountW-1:0]  count_q;

  logic               action_q;
  logic [MacW-1:0]    mac_q;
  logic [IpW-1:0]     req_q;
  logic [SfxW-1:0]    sfx_q;

  logic [TCW-1:0]     tcnt_q;
  logic [SCW-1:0]     scnt_q;
  logic [CLIENT_ENTRIES-1:0] valid_q;
  logic [POOL_SLOTS-1:0]     taken_q;

  logic               out_valid_q;
  logic               out_grant_q;
  logic [SfxW-1:0]    out_sfx_q;
  logic [IpW-1:0]     out_addr_q;

  logic [TIW-1:0]     tidx;
  logic [SIW-1:0]     sidx;
  logic [SCW-1:0]     n_act;
  logic [9:0]         slot_sfx;
  logic [8:0]         mark_off;
  logic               mark_in;
  logic [EntryW-1:0]  rd_entry;

  // config writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= PrefixRst;
      base_q   <= BaseRst;
      count_q  <= CountRst;
    end else if (cfg_valid_i) begin
      unique case (lal_reg_e'(cfg_index_i))
        REG_SERVER_PREFIX: prefix_q <= cfg_data_i[PrefixW-1:0];
        REG_POOL_BASE:     base_q   <= cfg_data_i[BaseW-1:0];
        REG_POOL_COUNT:    count_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // active slots, saturated to storage
  always_comb begin
    if ({2'b00, count_q} > 9'(POOL_SLOTS)) begin
      n_act = SCW'(POOL_SLOTS);
    end else begin
      n_act = SCW'(count_q);
    end
  end

  assign tidx     = tcnt_q[TIW-1:0];
  assign sidx     = scnt_q[SIW-1:0];
  assign slot_sfx = {2'b00, base_q} + 10'(scnt_q);
  assign mark_off = {1'b0, req_q[SfxW-1:0]} - {1'b0, base_q};
  assign mark_in  = (req_q[SfxW-1:0] >= base_q) && (10'(mark_off[7:0]) < 10'(n_act));

  always_comb begin
    sts_o.honour    = action_q && (req_q[IpW-1:SfxW] == prefix_q) && (req_q[SfxW-1:0] != '0);
    sts_o.tbl_end   = (tcnt_q == TCW'(CLIENT_ENTRIES));
    sts_o.tbl_empty = !valid_q[tidx];
    sts_o.tbl_match = (rd_entry[MacW-1:0] == mac_q);
    sts_o.slot_end  = (scnt_q == n_act);
    sts_o.slot_ok   = (slot_sfx <= 10'd255) && (slot_sfx != '0) && !taken_q[sidx];
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  // item capture and result suffix
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= in_user_i;
      mac_q    <= in_data_i[MacW-1:0];
      req_q    <= in_data_i[MacW+IpW-1:MacW];
      sfx_q    <= '0;
    end else if (cmd_i.mark) begin
      sfx_q <= req_q[SfxW-1:0];
    end else if (cmd_i.tbl_hit) begin
      sfx_q <= rd_entry[EntryW-1:MacW];
    end else if (cmd_i.slot_take) begin
      sfx_q <= slot_sfx[SfxW-1:0];
    end
  end

  // scan counters, slot bitmap and table valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q  <= '0;
      scnt_q  <= '0;
      valid_q <= '0;
      taken_q <= '0;
    end else begin
      if (cmd_i.load || cmd_i.slot_take) begin
        tcnt_q <= '0;
      end else if (cmd_i.tbl_inc) begin
        tcnt_q <= tcnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        scnt_q <= '0;
      end else if (cmd_i.slot_inc) begin
        scnt_q <= scnt_q + 1'b1;
      end
      if (cmd_i.tbl_wr) begin
        valid_q[tidx] <= 1'b1;
      end
      if (cmd_i.mark && mark_in) begin
        taken_q[mark_off[SIW-1:0]] <= 1'b1;
      end
      if (cmd_i.slot_take) begin
        taken_q[sidx] <= 1'b1;
      end
    end
  end

  // client table: host byte over hardware address
  lal_ram #(
    .WIDTH (EntryW),
    .DEPTH (CLIENT_ENTRIES)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tbl_wr),
    .waddr_i (tidx),
    .wdata_i ({sfx_q, mac_q}),
    .re_i    (cmd_i.tbl_rd),
    .raddr_i (tidx),
    .rdata_o (rd_entry)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_grant_q <= (sfx_q != '0);
      out_sfx_q   <= sfx_q;
      out_addr_q  <= (sfx_q != '0) ? {prefix_q, sfx_q} : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_grant_q;
  assign out_data_o  = {out_addr_q, out_sfx_q};

  // leases are never returned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(taken_q) & ~taken_q) == '0))
    else $error("pool slot released");

  // recorded clients are never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(valid_q) & ~valid_q) == '0))
    else $error("client entry invalidated");

  // a slot taken from the pool always yields a leasable suffix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slot_take |=> (sfx_q != '0))
    else $error("slot taken with zero suffix");

endmodule

/* rtl/lal_ctrl.sv */
// controller: sequences table lookup, slot search and table update per request
module lal_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lal_pkg::lal_sts_t sts_i,
  output lal_pkg::lal_cmd_t cmd_o
);
  import lal_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MARK  = 7'b0000010,
    ST_TRD   = 7'b0000100,
    ST_TCHK  = 7'b0001000,
    ST_SSCAN = 7'b0010000,
    ST_ESCAN = 7'b0100000,
    ST_FIN   = 7'b1000000
  } lal_state_e;

  lal_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MARK;
        end
      end
      ST_MARK: begin
        cmd_o.mark = sts_i.honour;
        state_d    = ST_TRD;
      end
      ST_TRD: begin
        if (sts_i.tbl_end) begin
          state_d = sts_i.honour ? ST_FIN : ST_SSCAN;
        end else begin
          cmd_o.tbl_rd = 1'b1;
          state_d      = ST_TCHK;
        end
      end
      ST_TCHK: begin
        if (sts_i.honour) begin
          if (sts_i.tbl_empty || sts_i.tbl_match) begin
            cmd_o.tbl_wr = 1'b1;
            state_d      = ST_FIN;
          end else begin
            cmd_o.tbl_inc = 1'b1;
            state_d       = ST_TRD;
          end
        end else if (!sts_i.tbl_empty && sts_i.tbl_match) begin
          cmd_o.tbl_hit = 1'b1;
          state_d       = ST_FIN;
        end else begin
          cmd_o.tbl_inc = 1'b1;
          state_d       = ST_TRD;
        end
      end
      ST_SSCAN: begin
        if (sts_i.slot_end) begin
          state_d = ST_FIN;
        end else if (sts_i.slot_ok) begin
          cmd_o.slot_take = 1'b1;
          state_d         = ST_ESCAN;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      ST_ESCAN: begin
        if (sts_i.tbl_end) begin
          state_d = ST_FIN;
        end else if (sts_i.tbl_empty) begin
          cmd_o.tbl_wr = 1'b1;
          state_d      = ST_FIN;
        end else begin
          cmd_o.tbl_inc = 1'b1;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a table write always closes the work on the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tbl_wr |=> (state_q == ST_FIN))
    else $error("table written mid scan");

endmodule

/* rtl/dhcp_lease_allocator_top.sv */
// top level of the dhcp lease allocator
// Lease pool allocator for a small DHCP server. Each input word is one lease
// request (tuser: action, 0 discover / 1 request) and produces exactly one
// result word (tuser: granted). A request for a nonzero host in the server's
// /24 is honoured as asked and recorded in the client table unless the table
// is full without the client; anything else returns the client's recorded
// suffix or takes the first free pool slot and records the client in the
// first empty entry, if any. One request is worked on at a time: the client
// table is a ram with a registered read, scanned with a read state and a check
// state per entry, and the slot bitmap is scanned at one slot per cycle. The
// result sits in an output register, so the next request is taken while a
// result waits; a second result stalls until the first is taken. Slot bitmap
// and table valid bits clear at reset; no clearing pass is needed.
module dhcp_lease_allocator_top #(
  parameter int POOL_SLOTS     = 64,
  parameter int CLIENT_ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lal_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lal_pkg::CfgDataW-1:0] cfg_data_i,
  // request words
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [79:0]                  s_axis_tdata,  // hw address[47:0], asked address[79:48]
  input  logic                         s_axis_tuser,  // action
  // result words
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [39:0]                  m_axis_tdata,  // lease_suffix[7:0], lease_address[39:8]
  output logic                         m_axis_tuser   // granted
);
  import lal_pkg::*;

  lal_cmd_t cmd;
  lal_sts_t sts;

  // config registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // request sequencing
  lal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, compares and result register
  lal_dp #(
    .POOL_SLOTS     (POOL_SLOTS),
    .CLIENT_ENTRIES (CLIENT_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* bench/dhcp_lease_allocator_top_tb.sv */
// self-checking testbench for the dhcp lease allocator top level
`timescale 1ns / 1ps

module dhcp_lease_allocator_top_tb;
  import lal_pkg::*;

  localparam int PoolSlots     = 64;
  localparam int ClientEntries = 16;
  localparam int KnownMacs     = 24;

  // index that maps to no register, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] RegUnknown = 2'd3;

  // one result word as the bench sees it
  typedef struct packed {
    logic            granted;
    logic [SfxW-1:0] sfx;
    logic [IpW-1:0]  addr;
  } lease_res_t;

  // lease predictor and queue of expected result words
  class lease_scoreboard;
    logic [PrefixW-1:0] prefix;
    logic [BaseW-1:0]   base;
    logic [CountW-1:0]  count;
    bit                 slot_taken[PoolSlots];
    logic [MacW-1:0]    hw_addr[ClientEntries];
    logic [SfxW-1:0]    host_byte[ClientEntries];
    lease_res_t         lease_q[$];
    int unsigned        errors;

    function new();
      prefix = PrefixRst;
      base   = BaseRst;
      count  = CountRst;
      errors = 0;
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      foreach (hw_addr[j]) begin
        hw_addr[j]   = '0;
        host_byte[j] = '0;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_SERVER_PREFIX: prefix = data[PrefixW-1:0];
        REG_POOL_BASE:     base   = data[BaseW-1:0];
        REG_POOL_COUNT:    count  = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function int active_slots();
      return (int'(count) > PoolSlots) ? PoolSlots : int'(count);
    endfunction

    // known client keeps its suffix, else first free leasable slot
    function logic [SfxW-1:0] take_lease(logic [MacW-1:0] mac);
      int sfx;
      for (int j = 0; j < ClientEntries; j++)
        if (host_byte[j] != 0 && hw_addr[j] == mac) return host_byte[j];
      for (int i = 0; i < active_slots(); i++) begin
        sfx = int'(base) + i;
        if (sfx > 255 || sfx == 0 || slot_taken[i]) continue;
        slot_taken[i] = 1'b1;
        for (int j = 0; j < ClientEntries; j++) begin
          if (host_byte[j] == 0) begin
            hw_addr[j]   = mac;
            host_byte[j] = sfx[SfxW-1:0];
            break;
          end
        end
        return sfx[SfxW-1:0];
      end
      return '0;
    endfunction

    function void note_request(bit action, logic [MacW-1:0] mac, logic [IpW-1:0] ip);
      lease_res_t      res;
      logic [SfxW-1:0] sfx;
      int              idx;
      if (action && ip[IpW-1:8] == prefix && ip[7:0] != 0) begin
        // honoured request, slot marked only when it lies in the pool
        sfx = ip[7:0];
        if (sfx >= base) begin
          idx = int'(sfx) - int'(base);
          if (idx < active_slots()) slot_taken[idx] = 1'b1;
        end
        for (int j = 0; j < ClientEntries; j++) begin
          if (host_byte[j] == 0 || hw_addr[j] == mac) begin
            hw_addr[j]   = mac;
            host_byte[j] = sfx;
            break;
          end
        end
      end else begin
        sfx = take_lease(mac);
      end
      res.granted = (sfx != 0);
      res.sfx     = sfx;
      res.addr    = (sfx != 0) ? {prefix, sfx} : '0;
      lease_q.push_back(res);
    endfunction

    function void check_result(logic granted, logic [SfxW-1:0] sfx, logic [IpW-1:0] addr);
      lease_res_t want;
      if (lease_q.size() == 0) begin
        $display("%0t: result word with none pending: granted %0d suffix %0d address %h",
                 $time, granted, sfx, addr);
        errors++;
        return;
      end
      want = lease_q.pop_front();
      if (granted !== want.granted) begin
        $display("%0t: granted expected %0d actual %0d", $time, want.granted, granted);
        errors++;
      end
      if (sfx !== want.sfx) begin
        $display("%0t: lease_suffix expected %0d actual %0d", $time, want.sfx, sfx);
        errors++;
      end
      if (addr !== want.addr) begin
        $display("%0t: lease_address expected %h actual %h", $time, want.addr, addr);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [79:0]         s_axis_tdata  = '0;  // hw address[47:0], asked address[79:48]
  logic                s_axis_tuser  = 1'b0; // action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;        // lease_suffix[7:0], lease_address[39:8]
  logic                m_axis_tuser;        // granted

  lease_scoreboard sb;
  logic [MacW-1:0] known_mac[KnownMacs];

  // idling control shared by both sides
  bit steady        = 1'b0;  // no random gaps on either side
  bit rx_hold_start = 1'b0;  // ask the result side for one long hold-off
  int rx_hold_left  = 0;

  dhcp_lease_allocator_top #(
    .POOL_SLOTS    (PoolSlots),
    .CLIENT_ENTRIES(ClientEntries)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: random back-pressure, or one long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_start) begin
      rx_hold_left  = 400;
      rx_hold_start = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 34);
    end
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8]);
  end

  // one register write on the configuration channel
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // all three registers, unused upper data bits filled with noise
  task automatic set_pool(logic [PrefixW-1:0] pfx, logic [BaseW-1:0] b, logic [CountW-1:0] n);
    write_reg(REG_SERVER_PREFIX, pfx);
    write_reg(REG_POOL_BASE, {16'($urandom), b});
    write_reg(REG_POOL_COUNT, {17'($urandom), n});
  endtask

  // offer one request word, random gaps ahead of it
  task automatic send_request(bit action, logic [MacW-1:0] mac, logic [IpW-1:0] ip);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ip, mac};
    s_axis_tuser  <= action;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(action, mac, ip);
  endtask

  // drop valid and wait until every pending lease has come back
  task automatic drain_leases();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.lease_q.size() != 0) @(posedge clk_i);
  endtask

  // requested address, mostly inside our subnet, some of it near the pool
  function automatic logic [IpW-1:0] pick_ip();
    int r;
    int host;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      host = int'(sb.base) + $urandom_range(0, int'(sb.count) + 3);
      if (host > 255) host = $urandom_range(1, 255);
      return {sb.prefix, 8'(host)};
    end
    if (r < 45) return {sb.prefix, 8'h00};
    if (r < 65) return $urandom;
    if (r < 75) return '0;
    return {sb.prefix, 8'($urandom)};
  endfunction

  task automatic random_requests(int items);
    logic [MacW-1:0] mac;
    for (int k = 0; k < items; k++) begin
      // reuse known clients most of the time so table hits happen
      if ($urandom_range(0, 99) < 65) mac = known_mac[$urandom_range(0, KnownMacs - 1)];
      else mac = {16'($urandom), 32'($urandom)};
      send_request(1'($urandom_range(0, 1)), mac, pick_ip());
    end
  endtask

  initial begin
    logic [PrefixW-1:0] pfx;
    sb = new();
    known_mac[0] = '0;
    known_mac[1] = '1;
    for (int k = 2; k < KnownMacs; k++) known_mac[k] = {16'($urandom), 32'($urandom)};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed requests on the reset pool
    pfx = sb.prefix;
    send_request(1'b0, known_mac[2], '0);               // new client
    send_request(1'b0, known_mac[2], '0);               // same client, recorded suffix
    send_request(1'b0, known_mac[0], '0);               // all-zero hardware address
    send_request(1'b0, known_mac[1], 32'hFFFF_FFFF);    // all-ones fields
    send_request(1'b1, known_mac[3], {pfx, 8'd120});    // honoured inside the pool
    send_request(1'b1, known_mac[3], {pfx, 8'd5});      // honoured outside the pool
    send_request(1'b1, known_mac[4], {pfx, 8'd0});      // host byte zero, allocates
    send_request(1'b1, known_mac[5], {24'h0A0000, 8'd7}); // foreign subnet
    send_request(1'b1, known_mac[6], '0);               // no address asked
    send_request(1'b1, known_mac[7], {pfx, 8'hFF});     // top host byte
    send_request(1'b1, known_mac[8], {pfx, 8'd100});    // slot already taken
    send_request(1'b0, known_mac[3], '0);               // offer returns honoured suffix
    for (int k = 9; k <= 16; k++)                      // fill the table, last one drops
      send_request(1'b0, known_mac[k], '0);
    send_request(1'b0, known_mac[16], '0);              // unrecorded client takes another slot
    send_request(1'b1, known_mac[17], {pfx, 8'd140});   // table full on acknowledge
    drain_leases();

    // write to an unused index must leave everything unchanged
    write_reg(RegUnknown, 24'($urandom));

    // suffix past 255
    set_pool(24'($urandom), 8'd250, 7'd10);
    random_requests(180);
    drain_leases();

    // base zero, slot 0 would give suffix zero
    set_pool(24'($urandom), 8'd0, 7'd3);
    random_requests(150);
    drain_leases();

    // empty pool
    set_pool(24'($urandom), 8'd1, 7'd0);
    random_requests(150);
    drain_leases();

    // count beyond storage saturates, prefix all zero, result side holds off
    set_pool(24'h000000, 8'd1, 7'd127);
    rx_hold_start = 1'b1;
    random_requests(250);
    drain_leases();

    // prefix all ones, base at the top, no idling at all
    set_pool(24'hFFFFFF, 8'd255, 7'd64);
    steady = 1'b1;
    random_requests(250);
    drain_leases();
    steady = 1'b0;

    // random pools in the legal range
    for (int p = 0; p < 4; p++) begin
      set_pool(24'($urandom), 8'($urandom_range(1, 255)), 7'($urandom_range(1, 64)));
      random_requests(215);
      drain_leases();
    end

    // late or stray result words would show up here
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.lease_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard
  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
